FILE: src/stgc_pkg.sv
// Shared types and constants for the sorted triple group counter.
// Used by stgc_front, stgc_queue, stgc_back and the top level.
`default_nettype none

package stgc_pkg;

  localparam int FIELD_W = 32;
  localparam int DATA_W  = 3 * FIELD_W;
  localparam logic [FIELD_W-1:0] CNT_MAX = '1;

  // record_kind codes
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_PAIR = 1'b1;

  // Record slots of one command, in output order
  localparam int REC_PAIR_A = 0;  // pair group closed by a key or predicate change
  localparam int REC_KEY_A  = 1;  // key group closed by a key change
  localparam int REC_PAIR_B = 2;  // pair group closed by end of stream
  localparam int REC_KEY_B  = 3;  // key group closed by end of stream
  localparam int REC_SLOTS  = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [REC_SLOTS-1:0] rec_mask_t;

  // One accepted item's worth of records to emit
  typedef struct packed {
    rec_mask_t          mask;
    logic [FIELD_W-1:0] key_a;
    logic [FIELD_W-1:0] pred_a;
    logic [FIELD_W-1:0] pcnt_a;
    logic [FIELD_W-1:0] kcnt_a;
    logic [FIELD_W-1:0] key_b;
    logic [FIELD_W-1:0] pred_b;
    logic [FIELD_W-1:0] pcnt_b;
    logic [FIELD_W-1:0] kcnt_b;
  } cmd_t;

  function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + FIELD_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: src/stgc_queue.sv
// Short command queue between the front and back parts.
// Depends on stgc_pkg for the command type and depth.
`default_nettype none

module stgc_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  stgc_pkg::cmd_t   push_cmd_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             head_valid_o,
  output stgc_pkg::cmd_t   head_cmd_o
);

  stgc_pkg::cmd_t                    mem_q [stgc_pkg::QUEUE_DEPTH];
  logic [stgc_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [stgc_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [stgc_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o       = (cnt_q == stgc_pkg::QCNT_W'(stgc_pkg::QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == stgc_pkg::QPTR_W'(stgc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + stgc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == stgc_pkg::QPTR_W'(stgc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + stgc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + stgc_pkg::QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - stgc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/stgc_front.sv
// Front part: accepts triples, tracks the open groups and classifies each
// request into a command of records to emit. Depends on stgc_pkg.
`default_nettype none

module stgc_front #(
  parameter int ID_BITS = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire                               cfg_wdata_i,
  input  wire                               in_fire_i,
  input  wire [stgc_pkg::FIELD_W-1:0]       subject_i,
  input  wire [stgc_pkg::FIELD_W-1:0]       predicate_i,
  input  wire [stgc_pkg::FIELD_W-1:0]       object_i,
  input  wire                               eos_i,
  output logic                              push_o,
  output stgc_pkg::cmd_t                    push_cmd_o
);

  localparam int IdW = (ID_BITS < stgc_pkg::FIELD_W) ? ID_BITS : stgc_pkg::FIELD_W;

  logic                          mode_q;
  logic                          have_q, have_d;
  logic [IdW-1:0]                ps_q, ps_d, pp_q, pp_d, po_q, po_d;
  logic [stgc_pkg::FIELD_W-1:0]  kcnt_q, kcnt_d, pcnt_q, pcnt_d;

  logic [IdW-1:0]                s, p, o, key, prev_key, new_key;
  logic                          rep, chg_key, chg_pred;
  logic [IdW-1:0]                ns, np, no;
  logic [stgc_pkg::FIELD_W-1:0]  nk, npc;

  assign s        = subject_i[IdW-1:0];
  assign p        = predicate_i[IdW-1:0];
  assign o        = object_i[IdW-1:0];
  assign key      = mode_q ? o : s;
  assign prev_key = mode_q ? po_q : ps_q;

  assign rep      = have_q && (s == ps_q) && (p == pp_q) && (o == po_q);
  assign chg_key  = have_q && !rep && (key != prev_key);
  assign chg_pred = have_q && !rep && !chg_key && (p != pp_q);

  // State after counting this triple, before any end-of-stream flush
  always_comb begin
    ns  = s;
    np  = p;
    no  = o;
    nk  = stgc_pkg::FIELD_W'(1);
    npc = stgc_pkg::FIELD_W'(1);
    if (rep) begin
      ns  = ps_q;
      np  = pp_q;
      no  = po_q;
      nk  = kcnt_q;
      npc = pcnt_q;
    end else if (chg_pred) begin
      nk  = stgc_pkg::sat_inc(kcnt_q);
    end else if (have_q && !chg_key) begin
      nk  = stgc_pkg::sat_inc(kcnt_q);
      npc = stgc_pkg::sat_inc(pcnt_q);
    end
  end

  assign new_key = mode_q ? no : ns;

  always_comb begin
    push_cmd_o = '0;
    push_cmd_o.mask[stgc_pkg::REC_PAIR_A] = chg_key || chg_pred;
    push_cmd_o.mask[stgc_pkg::REC_KEY_A]  = chg_key;
    push_cmd_o.mask[stgc_pkg::REC_PAIR_B] = eos_i;
    push_cmd_o.mask[stgc_pkg::REC_KEY_B]  = eos_i;
    push_cmd_o.key_a  = stgc_pkg::FIELD_W'(prev_key);
    push_cmd_o.pred_a = stgc_pkg::FIELD_W'(pp_q);
    push_cmd_o.pcnt_a = pcnt_q;
    push_cmd_o.kcnt_a = kcnt_q;
    push_cmd_o.key_b  = stgc_pkg::FIELD_W'(new_key);
    push_cmd_o.pred_b = stgc_pkg::FIELD_W'(np);
    push_cmd_o.pcnt_b = npc;
    push_cmd_o.kcnt_b = nk;
  end

  assign push_o = in_fire_i && (chg_key || chg_pred || eos_i);

  always_comb begin
    have_d = have_q;
    ps_d   = ps_q;
    pp_d   = pp_q;
    po_d   = po_q;
    kcnt_d = kcnt_q;
    pcnt_d = pcnt_q;
    if (in_fire_i) begin
      if (eos_i) begin
        // flush returns to the empty state
        have_d = 1'b0;
        ps_d   = '0;
        pp_d   = '0;
        po_d   = '0;
        kcnt_d = '0;
        pcnt_d = '0;
      end else begin
        have_d = 1'b1;
        ps_d   = ns;
        pp_d   = np;
        po_d   = no;
        kcnt_d = nk;
        pcnt_d = npc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      have_q <= 1'b0;
      ps_q   <= '0;
      pp_q   <= '0;
      po_q   <= '0;
      kcnt_q <= '0;
      pcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      have_q <= have_d;
      ps_q   <= ps_d;
      pp_q   <= pp_d;
      po_q   <= po_d;
      kcnt_q <= kcnt_d;
      pcnt_q <= pcnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/stgc_back.sv
// Back part: expands queued commands into records, one per cycle unless the
// output is stalled, into an output register. Depends on stgc_pkg.
`default_nettype none

module stgc_back (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               head_valid_i,
  input  stgc_pkg::cmd_t                    head_cmd_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              out_kind_o,
  output logic [stgc_pkg::FIELD_W-1:0]      out_key_o,
  output logic [stgc_pkg::FIELD_W-1:0]      out_pred_o,
  output logic [stgc_pkg::FIELD_W-1:0]      out_count_o,
  output logic                              out_last_o
);

  logic                          started_q, started_d;
  stgc_pkg::rec_mask_t           rem_q, rem_d, rem, cur, left;
  logic                          out_vld_q, out_vld_d;
  logic                          kind_q, last_q;
  logic [stgc_pkg::FIELD_W-1:0]  key_q, pred_q, cnt_q;
  logic                          kind_n;
  logic [stgc_pkg::FIELD_W-1:0]  key_n, pred_n, cnt_n;
  logic                          load, fire;

  assign load = !out_vld_q || out_ready_i;
  assign fire = load && head_valid_i;

  // pick the lowest pending record slot
  assign rem  = started_q ? rem_q : head_cmd_i.mask;
  assign cur  = rem & (~rem + stgc_pkg::REC_SLOTS'(1));
  assign left = rem & ~cur;

  always_comb begin
    kind_n = stgc_pkg::KIND_PAIR;
    key_n  = head_cmd_i.key_a;
    pred_n = head_cmd_i.pred_a;
    cnt_n  = head_cmd_i.pcnt_a;
    case (cur)
      stgc_pkg::rec_mask_t'(1 << stgc_pkg::REC_PAIR_A): begin
        kind_n = stgc_pkg::KIND_PAIR;
        key_n  = head_cmd_i.key_a;
        pred_n = head_cmd_i.pred_a;
        cnt_n  = head_cmd_i.pcnt_a;
      end
      stgc_pkg::rec_mask_t'(1 << stgc_pkg::REC_KEY_A): begin
        kind_n = stgc_pkg::KIND_KEY;
        key_n  = head_cmd_i.key_a;
        pred_n = '0;
        cnt_n  = head_cmd_i.kcnt_a;
      end
      stgc_pkg::rec_mask_t'(1 << stgc_pkg::REC_PAIR_B): begin
        kind_n = stgc_pkg::KIND_PAIR;
        key_n  = head_cmd_i.key_b;
        pred_n = head_cmd_i.pred_b;
        cnt_n  = head_cmd_i.pcnt_b;
      end
      stgc_pkg::rec_mask_t'(1 << stgc_pkg::REC_KEY_B): begin
        kind_n = stgc_pkg::KIND_KEY;
        key_n  = head_cmd_i.key_b;
        pred_n = '0;
        cnt_n  = head_cmd_i.kcnt_b;
      end
      default: begin
        kind_n = stgc_pkg::KIND_PAIR;
        key_n  = head_cmd_i.key_a;
        pred_n = head_cmd_i.pred_a;
        cnt_n  = head_cmd_i.pcnt_a;
      end
    endcase
  end

  assign pop_o = fire && (left == '0);

  always_comb begin
    started_d = started_q;
    rem_d     = rem_q;
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = head_valid_i;
    end
    if (fire) begin
      started_d = (left != '0);
      rem_d     = left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      started_q <= started_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q <= kind_n;
      key_q  <= key_n;
      pred_q <= pred_n;
      cnt_q  <= cnt_n;
      last_q <= (left == '0);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_kind_o  = kind_q;
  assign out_key_o   = key_q;
  assign out_pred_o  = pred_q;
  assign out_count_o = cnt_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

FILE: src/sorted_triple_group_counter.sv
// Sorted triple group counter: counts triples per key and per key-predicate.
// A request's records pass through the command queue and then the output register.
// Throughput: one request per cycle while the queue is not full; the back part
// emits one record per cycle unless stalled, one for each group a request closes.
// Reset clears the open groups, key_mode to subject, the queue and the output.
// Depends on stgc_pkg, stgc_front, stgc_queue and stgc_back.
`default_nettype none

module sorted_triple_group_counter #(
  parameter int ID_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_wdata_i,    // key_mode
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [stgc_pkg::DATA_W-1:0]      s_axis_tdata,   // subject_id, predicate_id, object_id
  input  wire                              s_axis_tlast,   // end_of_stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [stgc_pkg::DATA_W-1:0]      m_axis_tdata,   // key_out, pred_out, group_count
  output logic                             m_axis_tuser,   // record_kind
  output logic                             m_axis_tlast    // last_of_run
);

  localparam int FW = stgc_pkg::FIELD_W;

  logic                 full, push, pop, head_valid, in_fire;
  stgc_pkg::cmd_t       push_cmd, head_cmd;
  logic [FW-1:0]        key_out, pred_out, cnt_out;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  stgc_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .subject_i   (s_axis_tdata[FW-1:0]),
    .predicate_i (s_axis_tdata[2*FW-1:FW]),
    .object_i    (s_axis_tdata[3*FW-1:2*FW]),
    .eos_i       (s_axis_tlast),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  stgc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  stgc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_key_o    (key_out),
    .out_pred_o   (pred_out),
    .out_count_o  (cnt_out),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {cnt_out, pred_out, key_out};

endmodule

`default_nettype wire
